>>> design/ata_pkg.sv
// Shared types and constants of the ATA PIO sequencer.
package ata_pkg;

    // Operation codes of an input word
    localparam logic [1:0] OP_START_RD = 2'd0;
    localparam logic [1:0] OP_START_WR = 2'd1;
    localparam logic [1:0] OP_REPLY    = 2'd2;
    localparam logic [1:0] OP_HOST_WR  = 2'd3;

    // Result kinds
    localparam logic [2:0] K_NONE  = 3'd0;
    localparam logic [2:0] K_READ  = 3'd1;
    localparam logic [2:0] K_WRITE = 3'd2;
    localparam logic [2:0] K_HOST  = 3'd3;
    localparam logic [2:0] K_RDY   = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NODRV = 2'd1;
    localparam logic [1:0] ST_DEVER = 2'd2;
    localparam logic [1:0] ST_TMO   = 2'd3;

    // Device status bits
    localparam int B_BSY = 7;
    localparam int B_DF  = 5;
    localparam int B_DRQ = 3;
    localparam int B_ERR = 0;

    // Port offsets from the channel base
    localparam logic [15:0] OFF_DATA = 16'h0000;
    localparam logic [15:0] OFF_FEAT = 16'h0001;
    localparam logic [15:0] OFF_CNT  = 16'h0002;
    localparam logic [15:0] OFF_LBA0 = 16'h0003;
    localparam logic [15:0] OFF_LBA1 = 16'h0004;
    localparam logic [15:0] OFF_LBA2 = 16'h0005;
    localparam logic [15:0] OFF_SEL  = 16'h0006;
    localparam logic [15:0] OFF_CMD  = 16'h0007;
    localparam logic [15:0] OFF_ALT  = 16'h0206;

    localparam logic [7:0] CMD_READ  = 8'h20;
    localparam logic [7:0] CMD_WRITE = 8'h30;
    localparam logic [7:0] CMD_FLUSH = 8'hE7;
    localparam logic [7:0] SEL_LBA   = 8'hE0;

    localparam logic [8:0]  WORDS_PER_SECTOR = 9'd256;
    localparam logic [16:0] POLL_RESET       = 17'd100000;
    localparam logic [15:0] PRI_RESET        = 16'd496;
    localparam logic [15:0] SEC_RESET        = 16'd368;

    // Register indexes
    localparam logic [1:0] R_MASK  = 2'd0;
    localparam logic [1:0] R_LIMIT = 2'd1;
    localparam logic [1:0] R_PRI   = 2'd2;
    localparam logic [1:0] R_SEC   = 2'd3;

    // Burst head: words that come before the tail
    localparam logic [2:0] H_NONE = 3'd0;
    localparam logic [2:0] H_SEL  = 3'd1;
    localparam logic [2:0] H_TASK = 3'd2;
    localparam logic [2:0] H_HOST = 3'd3;
    localparam logic [2:0] H_PWR  = 3'd4;

    // Burst tail
    localparam logic [2:0] T_NONE  = 3'd0;
    localparam logic [2:0] T_FIN   = 3'd1;
    localparam logic [2:0] T_RD    = 3'd2;
    localparam logic [2:0] T_FLUSH = 3'd3;
    localparam logic [2:0] T_RDY   = 3'd4;

    typedef struct packed {
        logic [3:0]  present_mask;
        logic [16:0] poll_limit;
        logic [15:0] primary_base;
        logic [15:0] secondary_base;
    } t_cfg;

    // One burst of result words, as the front hands it to the back
    typedef struct packed {
        logic [2:0]  head;
        logic [2:0]  tail;
        logic [15:0] base;
        logic [15:0] rd_off;
        logic [15:0] data;
        logic [1:0]  status;
        logic [7:0]  sectors;
        logic [23:0] lba;
        logic        is_write;
    } t_desc;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] port;
        logic [15:0] data;
        logic        fin;
        logic [1:0]  status;
        logic        last;
    } t_item;

endpackage

>>> design/ata_front.sv
// Front: takes input words, steps the transfer state and emits burst descriptors.
module ata_front import ata_pkg::*; #(
    parameter int NUM_DRIVES  = 4,
    parameter int DELAY_READS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  logic [1:0]  i_operation,
    input  logic [1:0]  i_drive_index,
    input  logic [27:0] i_lba,
    input  logic [7:0]  i_sector_count,
    input  logic [15:0] i_word_value,
    input  t_cfg        i_cfg,
    output logic        o_push,
    output t_desc       o_desc
);

    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_BSY    = 4'd1;
    localparam logic [3:0] PH_SELDLY = 4'd2;
    localparam logic [3:0] PH_DRQ    = 4'd3;
    localparam logic [3:0] PH_RDATA  = 4'd4;
    localparam logic [3:0] PH_WDATA  = 4'd5;
    localparam logic [3:0] PH_SECDLY = 4'd6;
    localparam logic [3:0] PH_FLUSH  = 4'd7;

    localparam logic [2:0] DLY_INIT = 3'(DELAY_READS - 1);

    logic [3:0]  r_phase, n_phase;
    logic [15:0] r_base, n_base;
    logic        r_slave, n_slave;
    logic        r_write, n_write;
    logic [7:0]  r_sectors, n_sectors;
    logic [8:0]  r_words, n_words;
    logic [16:0] r_poll, n_poll;
    logic [2:0]  r_delay, n_delay;
    logic [27:0] r_lba, n_lba;

    logic        found;
    logic [1:0]  fpos;
    logic [2:0]  seen;
    logic [16:0] lim;
    logic        poll_hit;
    logic [7:0]  st;
    logic [8:0]  words_dec;
    logic [2:0]  aft_tail;
    logic [3:0]  aft_phase;
    logic [15:0] start_base;
    t_desc       d;

    // n-th present drive
    always_comb begin
        found = 1'b0;
        fpos  = '0;
        seen  = '0;
        for (int p = 0; p < 4; p++) begin
            if (p < NUM_DRIVES && i_cfg.present_mask[p] && !found) begin
                if (seen == {1'b0, i_drive_index}) begin
                    found = 1'b1;
                    fpos  = 2'(p);
                end
                seen = seen + 3'd1;
            end
        end
    end

    assign start_base = fpos[1] ? i_cfg.secondary_base : i_cfg.primary_base;
    assign lim        = (i_cfg.poll_limit == '0) ? 17'd1 : i_cfg.poll_limit;
    assign poll_hit   = r_poll >= lim;
    assign st         = i_word_value[7:0];
    assign words_dec  = r_words - 9'd1;

    // end of a sector or of the task file
    always_comb begin
        if (r_sectors != '0) begin
            aft_tail  = T_RD;
            aft_phase = PH_DRQ;
        end else if (r_write) begin
            aft_tail  = T_FLUSH;
            aft_phase = PH_FLUSH;
        end else begin
            aft_tail  = T_FIN;
            aft_phase = PH_IDLE;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_base    = r_base;
        n_slave   = r_slave;
        n_write   = r_write;
        n_sectors = r_sectors;
        n_words   = r_words;
        n_poll    = r_poll;
        n_delay   = r_delay;
        n_lba     = r_lba;
        d          = '0;
        d.head     = H_NONE;
        d.tail     = T_NONE;
        d.base     = r_base;
        d.rd_off   = OFF_CMD;
        d.status   = ST_OK;
        d.sectors  = r_sectors;
        d.lba      = r_lba[23:0];
        d.is_write = r_write;
        if (i_fire) begin
            if (i_operation == OP_START_RD || i_operation == OP_START_WR) begin
                if (r_phase == PH_IDLE) begin
                    if (!found) begin
                        d.tail   = T_FIN;
                        d.status = ST_NODRV;
                    end else begin
                        n_base    = start_base;
                        n_slave   = fpos[0];
                        n_write   = i_operation[0];
                        n_lba     = i_lba;
                        n_sectors = i_sector_count;
                        n_words   = '0;
                        n_poll    = 17'd1;
                        n_phase   = PH_BSY;
                        d.tail    = T_RD;
                        d.base    = start_base;
                    end
                end
            end else if (i_operation == OP_REPLY) begin
                unique case (r_phase)
                    PH_BSY: begin
                        if (st[B_BSY]) begin
                            if (poll_hit) begin
                                d.tail   = T_FIN;
                                d.status = ST_TMO;
                                n_phase  = PH_IDLE;
                            end else begin
                                d.tail = T_RD;
                                n_poll = r_poll + 17'd1;
                            end
                        end else begin
                            d.head   = H_SEL;
                            d.data   = {8'h00, SEL_LBA | {3'b000, r_slave, r_lba[27:24]}};
                            d.tail   = T_RD;
                            d.rd_off = OFF_ALT;
                            n_delay  = DLY_INIT;
                            n_phase  = PH_SELDLY;
                        end
                    end
                    PH_SELDLY, PH_SECDLY: begin
                        if (r_delay != '0) begin
                            d.tail   = T_RD;
                            d.rd_off = OFF_ALT;
                            n_delay  = r_delay - 3'd1;
                        end else begin
                            if (r_phase == PH_SELDLY) d.head = H_TASK;
                            d.tail  = aft_tail;
                            d.status = ST_OK;
                            n_phase = aft_phase;
                            n_poll  = 17'd1;
                        end
                    end
                    PH_DRQ: begin
                        if (st[B_DRQ]) begin
                            n_words = WORDS_PER_SECTOR;
                            if (r_write) begin
                                d.tail  = T_RDY;
                                n_phase = PH_WDATA;
                            end else begin
                                d.tail   = T_RD;
                                d.rd_off = OFF_DATA;
                                n_phase  = PH_RDATA;
                            end
                        end else if (poll_hit) begin
                            d.tail   = T_FIN;
                            d.status = ST_TMO;
                            n_phase  = PH_IDLE;
                        end else if (st[B_ERR] || st[B_DF]) begin
                            d.tail   = T_FIN;
                            d.status = ST_DEVER;
                            n_phase  = PH_IDLE;
                        end else begin
                            d.tail = T_RD;
                            n_poll = r_poll + 17'd1;
                        end
                    end
                    PH_RDATA: begin
                        d.head  = H_HOST;
                        d.data  = i_word_value;
                        n_words = words_dec;
                        if (words_dec != '0) begin
                            d.tail   = T_RD;
                            d.rd_off = OFF_DATA;
                        end else begin
                            n_sectors = r_sectors - 8'd1;
                            d.tail    = T_RD;
                            d.rd_off  = OFF_ALT;
                            n_delay   = DLY_INIT;
                            n_phase   = PH_SECDLY;
                        end
                    end
                    PH_FLUSH: begin
                        if (st[B_BSY] && !poll_hit) begin
                            d.tail = T_RD;
                            n_poll = r_poll + 17'd1;
                        end else begin
                            d.tail  = T_FIN;
                            n_phase = PH_IDLE;
                        end
                    end
                    default: ;
                endcase
            end else if (r_phase == PH_WDATA) begin
                d.head  = H_PWR;
                d.data  = i_word_value;
                n_words = words_dec;
                if (words_dec == '0) begin
                    n_sectors = r_sectors - 8'd1;
                    d.tail    = T_RD;
                    d.rd_off  = OFF_ALT;
                    n_delay   = DLY_INIT;
                    n_phase   = PH_SECDLY;
                end
            end
        end
    end

    assign o_push = i_fire && (d.head != H_NONE || d.tail != T_NONE);
    assign o_desc = d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_base    <= '0;
            r_slave   <= 1'b0;
            r_write   <= 1'b0;
            r_sectors <= '0;
            r_words   <= '0;
            r_poll    <= '0;
            r_delay   <= '0;
            r_lba     <= '0;
        end else begin
            r_phase   <= n_phase;
            r_base    <= n_base;
            r_slave   <= n_slave;
            r_write   <= n_write;
            r_sectors <= n_sectors;
            r_words   <= n_words;
            r_poll    <= n_poll;
            r_delay   <= n_delay;
            r_lba     <= n_lba;
        end
    end

endmodule

>>> design/ata_queue.sv
// Two-entry descriptor queue between front and back.
module ata_queue import ata_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    input  logic  i_pop,
    output logic  o_valid,
    output logic  o_full,
    output t_desc o_desc
);

    t_desc      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_valid = r_cnt != 2'd0;
    assign o_full  = r_cnt == 2'd2;
    assign o_desc  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_desc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

>>> design/ata_back.sv
// Back: expands a burst descriptor into result words, one per cycle while the output is not stalled.
module ata_back import ata_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_q_valid,
    input  t_desc i_desc,
    output logic  o_pop,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);

    logic [2:0] r_idx;
    logic       r_valid;
    t_item      r_item;
    t_item      item;
    logic [2:0] hcnt, tcnt, total, tidx;
    logic       load;

    always_comb begin
        case (i_desc.head)
            H_SEL, H_HOST, H_PWR: hcnt = 3'd1;
            H_TASK:               hcnt = 3'd6;
            default:              hcnt = 3'd0;
        endcase
        case (i_desc.tail)
            T_FIN, T_RD, T_RDY: tcnt = 3'd1;
            T_FLUSH:            tcnt = 3'd2;
            default:            tcnt = 3'd0;
        endcase
    end

    assign total = hcnt + tcnt;
    assign tidx  = r_idx - hcnt;

    always_comb begin
        item = '0;
        if (r_idx < hcnt) begin
            unique case (i_desc.head)
                H_SEL: begin
                    item.kind = K_WRITE;
                    item.port = i_desc.base + OFF_SEL;
                    item.data = i_desc.data;
                end
                H_TASK: begin
                    item.kind = K_WRITE;
                    unique case (r_idx)
                        3'd0: item.port = i_desc.base + OFF_FEAT;
                        3'd1: begin
                            item.port = i_desc.base + OFF_CNT;
                            item.data = {8'h00, i_desc.sectors};
                        end
                        3'd2: begin
                            item.port = i_desc.base + OFF_LBA0;
                            item.data = {8'h00, i_desc.lba[7:0]};
                        end
                        3'd3: begin
                            item.port = i_desc.base + OFF_LBA1;
                            item.data = {8'h00, i_desc.lba[15:8]};
                        end
                        3'd4: begin
                            item.port = i_desc.base + OFF_LBA2;
                            item.data = {8'h00, i_desc.lba[23:16]};
                        end
                        default: begin
                            item.port = i_desc.base + OFF_CMD;
                            item.data = {8'h00, i_desc.is_write ? CMD_WRITE : CMD_READ};
                        end
                    endcase
                end
                H_HOST: begin
                    item.kind = K_HOST;
                    item.data = i_desc.data;
                end
                default: begin
                    item.kind = K_WRITE;
                    item.port = i_desc.base + OFF_DATA;
                    item.data = i_desc.data;
                end
            endcase
        end else begin
            unique case (i_desc.tail)
                T_FIN: begin
                    item.kind   = K_NONE;
                    item.fin    = 1'b1;
                    item.status = i_desc.status;
                end
                T_RD: begin
                    item.kind = K_READ;
                    item.port = i_desc.base + i_desc.rd_off;
                end
                T_FLUSH: begin
                    item.port = i_desc.base + OFF_CMD;
                    if (tidx == 3'd0) begin
                        item.kind = K_WRITE;
                        item.data = {8'h00, CMD_FLUSH};
                    end else begin
                        item.kind = K_READ;
                    end
                end
                default: item.kind = K_RDY;
            endcase
        end
        item.last = r_idx == total - 3'd1;
    end

    assign load    = !r_valid || i_ready;
    assign o_pop   = load && i_q_valid && item.last;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (load && i_q_valid) r_item <= item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= i_q_valid;
            if (i_q_valid) r_idx <= item.last ? 3'd0 : r_idx + 3'd1;
        end
    end

endmodule

>>> design/ata_pio_sector_transfer_unit.sv
// Top level of the ATA PIO LBA28 host sequencer.
//
// ATA PIO LBA28 host sequencer. Input words (start read/write, device read
// reply, host write word) are taken at one per cycle: each word updates the
// transfer state in the cycle it is accepted and, where it causes results,
// leaves one burst descriptor in a two-entry queue. The back end plays each
// burst out one result word per cycle (one to eight words, the task-file
// burst being the longest) through an output register, so input and output
// stall independently. Input ready drops only while the queue holds two
// bursts. Every port read result must be answered by one device reply word.
// Registers (APB, 32-bit data): 0x0 present mask, 0x4 poll limit,
// 0x8 primary base, 0xC secondary base; write them only while idle.
module ata_pio_sector_transfer_unit import ata_pkg::*; #(
    parameter int NUM_DRIVES  = 4,
    parameter int DELAY_READS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input words
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [1:0]  i_drive_index,
    input  logic [27:0] i_lba,
    input  logic [7:0]  i_sector_count,
    input  logic [15:0] i_word_value,
    // result words
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_access_kind,
    output logic [15:0] o_port,
    output logic [15:0] o_bus_data,
    output logic        o_finished,
    output logic [1:0]  o_status_code,
    output logic        o_last,
    // APB config
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg  r_cfg;
    logic  fire, push, q_valid, q_full, pop;
    t_desc push_desc, q_desc;
    t_item item;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.present_mask   <= '0;
            r_cfg.poll_limit     <= POLL_RESET;
            r_cfg.primary_base   <= PRI_RESET;
            r_cfg.secondary_base <= SEC_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                R_MASK:  r_cfg.present_mask   <= pwdata[3:0];
                R_LIMIT: r_cfg.poll_limit     <= pwdata[16:0];
                R_PRI:   r_cfg.primary_base   <= pwdata[15:0];
                default: r_cfg.secondary_base <= pwdata[15:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            R_MASK:  prdata = {28'd0, r_cfg.present_mask};
            R_LIMIT: prdata = {15'd0, r_cfg.poll_limit};
            R_PRI:   prdata = {16'd0, r_cfg.primary_base};
            default: prdata = {16'd0, r_cfg.secondary_base};
        endcase
    end

    assign o_in_ready = !q_full;
    assign fire       = i_in_valid && o_in_ready;

    ata_front #(
        .NUM_DRIVES  (NUM_DRIVES),
        .DELAY_READS (DELAY_READS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_operation    (i_operation),
        .i_drive_index  (i_drive_index),
        .i_lba          (i_lba),
        .i_sector_count (i_sector_count),
        .i_word_value   (i_word_value),
        .i_cfg          (r_cfg),
        .o_push         (push),
        .o_desc         (push_desc)
    );

    ata_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (push_desc),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_desc  (q_desc)
    );

    ata_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_desc    (q_desc),
        .o_pop     (pop),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_item    (item)
    );

    assign o_access_kind = item.kind;
    assign o_port        = item.port;
    assign o_bus_data    = item.data;
    assign o_finished    = item.fin;
    assign o_status_code = item.status;
    assign o_last        = item.last;

endmodule

>>> design/ata_checker.sv
// Port-level checks of the sequencer and their binding to the top level.
module ata_checker import ata_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  o_access_kind,
    input logic [15:0] o_port,
    input logic [15:0] o_bus_data,
    input logic        o_finished,
    input logic [1:0]  o_status_code,
    input logic        o_last
);

    // a finishing word is kind none and ends its step
    a_fin_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_finished |-> o_access_kind == K_NONE && o_last)
        else $error("finish word malformed");

    a_none_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_access_kind == K_NONE |-> o_finished)
        else $error("kind none without finish");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status_code != ST_OK |-> o_finished)
        else $error("status on a non-finishing word");

    a_noport: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_access_kind == K_HOST || o_access_kind == K_RDY)
        |-> o_port == 16'd0)
        else $error("port set on host word");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_port)
        && $stable(o_bus_data) && $stable(o_access_kind))
        else $error("stalled word changed");

endmodule

bind ata_pio_sector_transfer_unit ata_checker u_ata_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_access_kind (o_access_kind),
    .o_port        (o_port),
    .o_bus_data    (o_bus_data),
    .o_finished    (o_finished),
    .o_status_code (o_status_code),
    .o_last        (o_last)
);
